[src/jllc_pkg.sv]
package jllc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;
  localparam int unsigned SYM_W = 5;

  typedef logic [SYM_W-1:0] sym_t;

  // grammar symbols: terminals follow token kind plus one, then nonterminals
  localparam sym_t SYM_NONE     = 5'd0;
  localparam sym_t SYM_LBRACE   = 5'd1;
  localparam sym_t SYM_RBRACE   = 5'd2;
  localparam sym_t SYM_LBRACK   = 5'd3;
  localparam sym_t SYM_RBRACK   = 5'd4;
  localparam sym_t SYM_COLON    = 5'd5;
  localparam sym_t SYM_COMMA    = 5'd6;
  localparam sym_t SYM_STRING   = 5'd7;
  localparam sym_t SYM_NUMBER   = 5'd8;
  localparam sym_t SYM_IDENT    = 5'd9;
  localparam sym_t SYM_DOC      = 5'd10;
  localparam sym_t SYM_VALUE    = 5'd11;
  localparam sym_t SYM_OBJECT   = 5'd12;
  localparam sym_t SYM_OBJ_BODY = 5'd13;
  localparam sym_t SYM_OBJ_ELMS = 5'd14;
  localparam sym_t SYM_OBJ_TAIL = 5'd15;
  localparam sym_t SYM_OBJ_ELEM = 5'd16;
  localparam sym_t SYM_ARRAY    = 5'd17;
  localparam sym_t SYM_ARR_BODY = 5'd18;
  localparam sym_t SYM_ARR_ELMS = 5'd19;
  localparam sym_t SYM_ARR_TAIL = 5'd20;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_AFTER_DOC = 3'd2;
  localparam logic [2:0] ERR_MISMATCH  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // right-hand side, index 0 is the leftmost symbol
  typedef logic [2:0][SYM_W-1:0] rhs_t;

  typedef struct packed {
    logic       done;
    logic       doc_done;
    logic [2:0] err;
  } par_res_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       doc_done;
    logic [2:0] err;
  } result_t;

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_STRING = 6'b000010,
    M_ESC    = 6'b000100,
    M_HEX    = 6'b001000,
    M_NUMBER = 6'b010000,
    M_IDENT  = 6'b100000
  } lex_mode_e;

  // ll(1) table: expansion of top for lookahead tok, all zero when no rule
  function automatic rhs_t expand(sym_t top, sym_t tok);
    rhs_t r;
    r = '0;
    case (top)
      SYM_DOC: begin
        if (tok == SYM_LBRACE) r = {SYM_NONE, SYM_NONE, SYM_OBJECT};
        else if (tok == SYM_LBRACK) r = {SYM_NONE, SYM_NONE, SYM_ARRAY};
      end
      SYM_VALUE: begin
        if (tok == SYM_LBRACE) r = {SYM_NONE, SYM_NONE, SYM_OBJECT};
        else if (tok == SYM_LBRACK) r = {SYM_NONE, SYM_NONE, SYM_ARRAY};
        else if (tok inside {SYM_STRING, SYM_NUMBER, SYM_IDENT}) r = {SYM_NONE, SYM_NONE, tok};
      end
      SYM_OBJECT: begin
        if (tok == SYM_LBRACE) r = {SYM_NONE, SYM_OBJ_BODY, SYM_LBRACE};
      end
      SYM_OBJ_BODY: begin
        if (tok == SYM_RBRACE) r = {SYM_NONE, SYM_NONE, SYM_RBRACE};
        else if (tok == SYM_STRING) r = {SYM_NONE, SYM_NONE, SYM_OBJ_ELMS};
      end
      SYM_OBJ_ELMS: begin
        if (tok == SYM_STRING) r = {SYM_NONE, SYM_OBJ_TAIL, SYM_OBJ_ELEM};
      end
      SYM_OBJ_TAIL: begin
        if (tok == SYM_COMMA) r = {SYM_NONE, SYM_OBJ_ELMS, SYM_COMMA};
        else if (tok == SYM_RBRACE) r = {SYM_NONE, SYM_NONE, SYM_RBRACE};
      end
      SYM_OBJ_ELEM: begin
        if (tok == SYM_STRING) r = {SYM_VALUE, SYM_COLON, SYM_STRING};
      end
      SYM_ARRAY: begin
        if (tok == SYM_LBRACK) r = {SYM_NONE, SYM_ARR_BODY, SYM_LBRACK};
      end
      SYM_ARR_BODY: begin
        if (tok == SYM_RBRACK) r = {SYM_NONE, SYM_NONE, SYM_RBRACK};
        else if (tok inside {SYM_LBRACE, SYM_LBRACK, SYM_STRING, SYM_NUMBER, SYM_IDENT})
          r = {SYM_NONE, SYM_NONE, SYM_ARR_ELMS};
      end
      SYM_ARR_ELMS: begin
        if (tok inside {SYM_LBRACE, SYM_LBRACK, SYM_STRING, SYM_NUMBER, SYM_IDENT})
          r = {SYM_NONE, SYM_ARR_TAIL, SYM_VALUE};
      end
      SYM_ARR_TAIL: begin
        if (tok == SYM_COMMA) r = {SYM_NONE, SYM_ARR_ELMS, SYM_COMMA};
        else if (tok == SYM_RBRACK) r = {SYM_NONE, SYM_NONE, SYM_RBRACK};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/jllc_ram.sv]
module jllc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/jllc_parser.sv]
module jllc_parser import jllc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  sym_t     tok_i,
  output par_res_t res_o
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    P_IDLE  = 5'b00001,
    P_POP   = 5'b00010,
    P_CHECK = 5'b00100,
    P_PUSH  = 5'b01000,
    P_LEFT  = 5'b10000
  } pstate_e;

  pstate_e        state_q, state_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic           e0_q, e0_d;
  par_res_t       res_q, res_d;
  sym_t           tok_q, tok_d;
  sym_t           top_q, top_d;
  rhs_t           rhs_q, rhs_d;
  logic           hi_q, hi_d;
  logic           cache_q, cache_d;
  logic           zero_q, zero_d;

  logic [SPW-1:0] sp_m1;
  logic           full;
  sym_t           rd_data;
  sym_t           top;
  rhs_t           exp_rhs;
  sym_t           push_sym;
  logic           we;

  assign sp_m1    = sp_q - SPW'(1);
  assign full     = sp_q >= SPW'(STACK_DEPTH);
  // entry zero holds the document symbol until first written
  assign top      = cache_q ? top_q : (zero_q ? SYM_DOC : rd_data);
  assign exp_rhs  = expand(top, tok_q);
  assign push_sym = hi_q ? rhs_q[2] : rhs_q[1];

  jllc_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (push_sym),
    .raddr_i (sp_m1[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    sp_d    = sp_q;
    res_d   = '0;
    tok_d   = tok_q;
    top_d   = top_q;
    rhs_d   = rhs_q;
    hi_d    = hi_q;
    cache_d = cache_q;
    zero_d  = zero_q;
    we      = 1'b0;
    case (state_q)
      P_IDLE: begin
        if (start_i) begin
          tok_d   = tok_i;
          state_d = P_POP;
        end
      end
      P_POP: begin
        if (sp_q == '0) begin
          res_d   = '{done: 1'b1, doc_done: 1'b0, err: ERR_AFTER_DOC};
          state_d = P_IDLE;
        end else begin
          sp_d    = sp_m1;
          cache_d = 1'b0;
          zero_d  = (sp_m1 == '0) && !e0_q;
          state_d = P_CHECK;
        end
      end
      P_CHECK: begin
        if (top == tok_q) begin
          res_d   = '{done: 1'b1, doc_done: (sp_q == '0), err: ERR_NONE};
          state_d = P_IDLE;
        end else if (exp_rhs == '0) begin
          res_d   = '{done: 1'b1, doc_done: 1'b0, err: ERR_MISMATCH};
          state_d = P_IDLE;
        end else begin
          rhs_d   = exp_rhs;
          hi_d    = 1'b1;
          state_d = P_PUSH;
        end
      end
      P_PUSH: begin
        if (push_sym != SYM_NONE && full) begin
          res_d   = '{done: 1'b1, doc_done: 1'b0, err: ERR_OVERFLOW};
          state_d = P_IDLE;
        end else begin
          if (push_sym != SYM_NONE) begin
            we   = 1'b1;
            sp_d = sp_q + SPW'(1);
          end
          if (hi_q) begin
            hi_d = 1'b0;
          end else begin
            state_d = P_LEFT;
          end
        end
      end
      P_LEFT: begin
        // leftmost symbol is pushed and popped at once, kept in a register
        if (full) begin
          res_d   = '{done: 1'b1, doc_done: 1'b0, err: ERR_OVERFLOW};
          state_d = P_IDLE;
        end else begin
          top_d   = rhs_q[0];
          cache_d = 1'b1;
          state_d = P_CHECK;
        end
      end
      default: state_d = P_IDLE;
    endcase
  end

  assign e0_d = e0_q | (we && sp_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      sp_q    <= SPW'(1);
      e0_q    <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      e0_q    <= e0_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_d;
    top_q   <= top_d;
    rhs_q   <= rhs_d;
    hi_q    <= hi_d;
    cache_q <= cache_d;
    zero_q  <= zero_d;
  end

  assign res_o = res_q;

endmodule

[src/json_ll1_syntax_checker_top.sv]
// JSON syntax checker, one byte of text per input transfer.
// Input channel: in_valid_i / in_ready_o carry byte_in_i. Output channel:
// out_valid_o / out_ready_i carry one token result: token_kind_o,
// document_done_o, error_code_o and last_in_run_o (set on the final
// result of a byte). A byte gives no result, one, or two when it ends a
// number or identifier and is itself a punctuation token or bad character.
// A byte that forms no token passes the lexer step and the block is then
// ready again. A token adds the parser walk over the symbol stack: a pop
// and a compare, plus push steps and a compare per grammar rule expanded,
// paced by the stack RAM with one write and one read port and the one
// shared symbol compare. Results leave at one per cycle unless stalled.
// The block takes one byte at a time and is not ready while it works; the
// last result sits in an output register, so the next byte is taken while
// the receiver stalls. An earlier result of the same byte waits in the
// block until the receiver takes the one ahead of it.
// Reset empties the lexer and loads the stack with the document symbol;
// there is no clearing pass. The first error is reported once, then every
// byte is taken and dropped until reset.
module json_ll1_syntax_checker_top import jllc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_kind_o,
  output logic       document_done_o,
  output logic [2:0] error_code_o,
  output logic       last_in_run_o
);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LBRACK = 4'd2;
  localparam logic [3:0] KIND_RBRACK = 4'd3;
  localparam logic [3:0] KIND_COLON  = 4'd4;
  localparam logic [3:0] KIND_COMMA  = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_NUMBER = 4'd7;
  localparam logic [3:0] KIND_IDENT  = 4'd8;

  typedef enum logic [3:0] {
    S_IN   = 4'b0001,
    S_LEX  = 4'b0010,
    S_FEED = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  lex_mode_e  mode_q, mode_d;
  logic [1:0] hex_q, hex_d;
  logic       err_q, err_d;
  logic [1:0] n_q, n_d;
  logic       idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       again_q, again_d;
  logic [3:0] kind_q, kind_d;
  result_t    res_q [2];
  result_t    res_d [2];
  result_t    out_q, out_d;
  logic       out_last_q, out_last_d;

  logic       is_punct, is_digit, is_alpha, is_space, num_start, num_cont;
  logic [3:0] pkind;
  logic       par_start;
  logic [3:0] start_kind;
  sym_t       par_tok;
  par_res_t   par_res;
  logic       out_free, out_load, last_sel;
  state_e     fin_state;

  always_comb begin
    is_punct = 1'b1;
    pkind    = KIND_LBRACE;
    case (byte_q)
      CH_LBRACE: pkind = KIND_LBRACE;
      CH_RBRACE: pkind = KIND_RBRACE;
      CH_LBRACK: pkind = KIND_LBRACK;
      CH_RBRACK: pkind = KIND_RBRACK;
      CH_COLON:  pkind = KIND_COLON;
      CH_COMMA:  pkind = KIND_COMMA;
      default:   is_punct = 1'b0;
    endcase
  end

  assign is_digit  = byte_q inside {[CH_0:CH_9]};
  assign is_alpha  = byte_q inside {[CH_UP_A:CH_UP_Z], [CH_LOW_A:CH_LOW_Z]};
  assign is_space  = byte_q inside {CH_SPACE, [CH_TAB:CH_CR]};
  assign num_start = is_digit || (byte_q inside {CH_MINUS, CH_DOT});
  assign num_cont  = num_start || (byte_q inside {CH_LOW_E, CH_UP_E});

  assign in_ready_o = (state_q == S_IN);
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_sel   = ({1'b0, idx_q} == (n_q - 2'd1));
  assign fin_state  = (n_q != '0) ? S_OUT : S_IN;
  assign par_tok    = SYM_W'(start_kind) + SYM_W'(1);

  jllc_parser #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (par_start),
    .tok_i   (par_tok),
    .res_o   (par_res)
  );

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    hex_d      = hex_q;
    err_d      = err_q;
    n_d        = n_q;
    idx_d      = idx_q;
    byte_d     = byte_q;
    again_d    = again_q;
    kind_d     = kind_q;
    res_d      = res_q;
    par_start  = 1'b0;
    start_kind = KIND_STRING;
    out_load   = 1'b0;
    case (state_q)
      S_IN: begin
        if (in_valid_i) begin
          byte_d  = byte_in_i;
          n_d     = '0;
          idx_d   = 1'b0;
          again_d = 1'b0;
          if (!err_q) begin
            state_d = S_LEX;
          end
        end
      end
      S_LEX: begin
        state_d = fin_state;
        case (mode_q)
          M_IDLE: begin
            if (is_punct) begin
              par_start  = 1'b1;
              start_kind = pkind;
              again_d    = 1'b0;
              state_d    = S_FEED;
            end else if (num_start) begin
              mode_d = M_NUMBER;
            end else if (is_alpha) begin
              mode_d = M_IDENT;
            end else if (byte_q == CH_QUOTE) begin
              mode_d = M_STRING;
            end else if (!is_space) begin
              // bad char reports kind zero
              res_d[n_q[0]] = '{kind: KIND_LBRACE, doc_done: 1'b0, err: ERR_BAD_CHAR};
              n_d           = n_q + 2'd1;
              err_d         = 1'b1;
              state_d       = S_OUT;
            end
          end
          M_STRING: begin
            if (byte_q == CH_BSLASH) begin
              mode_d = M_ESC;
            end else if (byte_q == CH_QUOTE) begin
              mode_d     = M_IDLE;
              par_start  = 1'b1;
              start_kind = KIND_STRING;
              again_d    = 1'b0;
              state_d    = S_FEED;
            end
          end
          M_ESC: begin
            if (byte_q == CH_LOW_U) begin
              hex_d  = '0;
              mode_d = M_HEX;
            end else begin
              mode_d = M_STRING;
            end
          end
          M_HEX: begin
            hex_d = hex_q + 2'd1;
            if (hex_q == 2'd3) begin
              mode_d = M_STRING;
            end
          end
          M_NUMBER: begin
            if (!num_cont) begin
              mode_d     = M_IDLE;
              par_start  = 1'b1;
              start_kind = KIND_NUMBER;
              again_d    = 1'b1;
              state_d    = S_FEED;
            end
          end
          M_IDENT: begin
            if (!is_alpha) begin
              mode_d     = M_IDLE;
              par_start  = 1'b1;
              start_kind = KIND_IDENT;
              again_d    = 1'b1;
              state_d    = S_FEED;
            end
          end
          default: mode_d = M_IDLE;
        endcase
        if (par_start) begin
          kind_d = start_kind;
        end
      end
      S_FEED: begin
        if (par_res.done) begin
          res_d[n_q[0]] = '{kind: kind_q, doc_done: par_res.doc_done, err: par_res.err};
          n_d           = n_q + 2'd1;
          if (par_res.err != ERR_NONE) begin
            err_d   = 1'b1;
            state_d = S_OUT;
          end else if (again_q) begin
            // ending byte goes through the lexer once more
            again_d = 1'b0;
            state_d = S_LEX;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_sel) begin
            state_d = S_IN;
          end else begin
            idx_d = 1'b1;
          end
        end
      end
      default: state_d = S_IN;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);
  assign out_d       = out_load ? res_q[idx_q] : out_q;
  assign out_last_d  = out_load ? last_sel : out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      mode_q      <= M_IDLE;
      hex_q       <= '0;
      err_q       <= 1'b0;
      n_q         <= '0;
      idx_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      hex_q       <= hex_d;
      err_q       <= err_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    again_q    <= again_d;
    kind_q     <= kind_d;
    res_q      <= res_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign token_kind_o    = out_q.kind;
  assign document_done_o = out_q.doc_done;
  assign error_code_o    = out_q.err;
  assign last_in_run_o   = out_last_q;

  a_err_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FEED && par_res.done && par_res.err != ERR_NONE)
      |=> (err_q && state_q == S_OUT))
    else $error("parser error not latched");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    par_start |-> (state_q == S_LEX && !err_q))
    else $error("parser started outside lexer step or after error");

  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (n_q == 2'd1 || n_q == 2'd2))
    else $error("result drain with bad count");

  a_feed_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FEED && par_res.done) |=> !par_res.done)
    else $error("parser reported twice");

endmodule
